### rtl/qlr_pkg.sv
// Shared types and constants for the int8 quantized linear + ReLU core.
`timescale 1ns / 1ps
package qlr_pkg;

  // Field widths
  localparam int ACT_W    = 8;
  localparam int WGT_W    = 8;
  localparam int BIAS_W   = 32;
  localparam int ACC_W    = 32;
  localparam int MULT_W   = 31;
  localparam int SHIFT_W  = 6;
  localparam int OUT_W    = 47;
  localparam int SCALED_W = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Queue depths
  localparam int MIDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  // Register reset values
  localparam logic [MULT_W-1:0]  MULT_RST  = MULT_W'(65536);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(32);

  // Largest activation, 2^47-1
  localparam logic [OUT_W-1:0] ACT_MAX = {OUT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ZP   = 4'd0,
    REG_WGT_ZP  = 4'd1,
    REG_MULT    = 4'd2,
    REG_SHIFT   = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ACT_W-1:0]  act_value;
    logic signed [WGT_W-1:0]  wgt_value;
    logic signed [BIAS_W-1:0] bias_value;
    logic                     last_element;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] activation;
    logic             saturated;
  } out_word_t;

  // Finished dot product handed from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0]  acc;
    logic signed [BIAS_W-1:0] bias;
  } mid_word_t;

  typedef struct packed {
    logic signed [ACT_W-1:0] in_zp;
    logic signed [WGT_W-1:0] wgt_zp;
    logic [MULT_W-1:0]       scale_mult;
    logic [SHIFT_W-1:0]      scale_shift;
  } cfg_t;

endpackage

### rtl/int8_quantized_linear_relu_core.sv
// Top level of the int8 quantized linear + ReLU neuron core.
`timescale 1ns / 1ps
// One output neuron of an asymmetric int8 linear layer with ReLU. Push one
// (activation, weight) word per cycle; while in_full is low, the front end
// subtracts the zero points, multiplies and adds into a wrapping 32-bit
// accumulator at a rate of one word per clock. The word marked last_element
// also carries the bias (16 fractional bits); its finished sum goes into a
// 4-entry queue and the accumulator clears, so the next dot product can start
// in the following cycle. The back end takes one finished sum at a time (queue
// pop, 32x31 scale multiply, arithmetic shift, bias add with ReLU and 47-bit
// saturation) and writes a 2-entry result FIFO. in_full rises only when 4
// finished sums are waiting, i.e. when last words arrive faster than the back
// end retires them or the reader stalls. Configuration (index 0 input zero
// point, 1 weight zero point, 2 scale multiplier, 3 scale shift; other
// indexes ignored) is always ready and must only be written while no word
// is in flight.
module int8_quantized_linear_relu_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input word channel
  input  logic                               in_push,
  input  qlr_pkg::in_word_t                  in_word,
  output logic                               in_full,
  // result word channel
  output qlr_pkg::out_word_t                 out_word,
  output logic                               out_empty,
  input  logic                               pop,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qlr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import qlr_pkg::*;

  cfg_t      cfg_r;
  mid_word_t mid_wdata, mid_rdata;
  logic      mid_wr, mid_rd, mid_full, mid_empty;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_zp       <= '0;
      cfg_r.wgt_zp      <= '0;
      cfg_r.scale_mult  <= MULT_RST;
      cfg_r.scale_shift <= SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_ZP:  cfg_r.in_zp       <= cfg_data[ACT_W-1:0];
        REG_WGT_ZP: cfg_r.wgt_zp      <= cfg_data[WGT_W-1:0];
        REG_MULT:   cfg_r.scale_mult  <= cfg_data[MULT_W-1:0];
        REG_SHIFT:  cfg_r.scale_shift <= cfg_data[SHIFT_W-1:0];
        default:    ; // unmapped index, dropped
      endcase
    end
  end

  qlr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .mid_wr    (mid_wr),
    .mid_wdata (mid_wdata),
    .mid_full  (mid_full)
  );

  qlr_midq u_midq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  qlr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_rdata (mid_rdata),
    .mid_empty (mid_empty),
    .mid_rd    (mid_rd),
    .out_word  (out_word),
    .out_empty (out_empty),
    .pop       (pop)
  );

endmodule

### rtl/qlr_midq.sv
// Small FIFO of finished dot products between front and back.
`timescale 1ns / 1ps
module qlr_midq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  qlr_pkg::mid_word_t  wr_data,
  output logic                full,
  input  logic                rd_en,
  output qlr_pkg::mid_word_t  rd_data,
  output logic                empty
);
  import qlr_pkg::*;

  localparam int PTR_W = $clog2(MIDQ_DEPTH);
  localparam int CNT_W = $clog2(MIDQ_DEPTH + 1);

  mid_word_t        mem_r [MIDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == CNT_W'(MIDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full) else $error("midq written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty) else $error("midq read while empty");

  a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && !wr_en) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("midq count did not drop on read");

endmodule

### rtl/qlr_front.sv
// Front end: zero-point MAC per word, hands finished sums to the back.
`timescale 1ns / 1ps
module qlr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  qlr_pkg::cfg_t       cfg,
  input  logic                in_push,
  input  qlr_pkg::in_word_t   in_word,
  output logic                in_full,
  output logic                mid_wr,
  output qlr_pkg::mid_word_t  mid_wdata,
  input  logic                mid_full
);
  import qlr_pkg::*;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACT_W:0]   a_d;
  logic signed [WGT_W:0]   w_d;
  logic signed [ACT_W+WGT_W+1:0] prod;
  logic signed [ACC_W-1:0] acc_sum;
  logic                    accept;

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  // 9-bit differences, 18-bit product, wrapping 32-bit sum
  assign a_d     = (ACT_W+1)'(in_word.act_value) - (ACT_W+1)'(cfg.in_zp);
  assign w_d     = (WGT_W+1)'(in_word.wgt_value) - (WGT_W+1)'(cfg.wgt_zp);
  assign prod    = a_d * w_d;
  assign acc_sum = acc_r + ACC_W'(prod);

  assign mid_wr         = accept && in_word.last_element;
  assign mid_wdata.acc  = acc_sum;
  assign mid_wdata.bias = in_word.bias_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      acc_r <= in_word.last_element ? '0 : acc_sum;
    end
  end

endmodule

### rtl/qlr_back.sv
// Back end: scale, shift, bias, ReLU and saturate, plus the result FIFO.
`timescale 1ns / 1ps
module qlr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qlr_pkg::cfg_t       cfg,
  input  qlr_pkg::mid_word_t  mid_rdata,
  input  logic                mid_empty,
  output logic                mid_rd,
  output qlr_pkg::out_word_t  out_word,
  output logic                out_empty,
  input  logic                pop
);
  import qlr_pkg::*;

  localparam int OPTR_W = $clog2(OUTQ_DEPTH);
  localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [ACC_W-1:0]    acc_r;
  logic signed [BIAS_W-1:0]   bias_r;
  logic signed [SCALED_W-1:0] prod_r, scaled_r;
  logic signed [SCALED_W-1:0] sum;
  out_word_t                  res;

  out_word_t         oq_r [OUTQ_DEPTH];
  logic [OPTR_W-1:0] owr_r, ord_r;
  logic [OCNT_W-1:0] ocnt_r;
  logic              oq_full, oq_wr, oq_rd;

  assign oq_full   = (ocnt_r == OCNT_W'(OUTQ_DEPTH));
  assign out_empty = (ocnt_r == '0);
  assign out_word  = oq_r[ord_r];
  assign oq_rd     = pop && !out_empty;
  assign oq_wr     = (state_r == ST_FIN) && !oq_full;
  assign mid_rd    = (state_r == ST_IDLE) && !mid_empty;

  // bias with 16 fractional bits added to the floored product
  assign sum = scaled_r + SCALED_W'(bias_r);

  always_comb begin
    res.activation = '0;
    res.saturated  = 1'b0;
    if (!sum[SCALED_W-1] && (sum != '0)) begin
      if (|sum[SCALED_W-2:OUT_W]) begin
        res.activation = ACT_MAX;
        res.saturated  = 1'b1;
      end else begin
        res.activation = sum[OUT_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (!mid_empty) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_FIN;
      ST_FIN:   if (!oq_full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mid_rd) begin
      acc_r  <= mid_rdata.acc;
      bias_r <= mid_rdata.bias;
    end
    if (state_r == ST_MUL) begin
      prod_r <= acc_r * $signed({1'b0, cfg.scale_mult});
    end
    if (state_r == ST_SHIFT) begin
      scaled_r <= prod_r >>> cfg.scale_shift;
    end
    if (oq_wr) begin
      oq_r[owr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      owr_r   <= '0;
      ord_r   <= '0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (oq_wr) begin
        owr_r <= (owr_r == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_r + 1'b1;
      end
      if (oq_rd) begin
        ord_r <= (ord_r == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_r + 1'b1;
      end
      case ({oq_wr, oq_rd})
        2'b10:   ocnt_r <= ocnt_r + 1'b1;
        2'b01:   ocnt_r <= ocnt_r - 1'b1;
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OCNT_W'(OUTQ_DEPTH)) else $error("result FIFO overfilled");

  a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !oq_full) |=> (state_r == ST_IDLE))
    else $error("back did not retire result");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mid_rd |=> (state_r == ST_MUL)) else $error("midq pop outside idle");

endmodule

### sim/tb.sv
// Self-checking testbench for the int8 quantized linear + ReLU neuron core.
`timescale 1ns / 1ps
module tb;
  import qlr_pkg::*;

  // Timing and run shape
  localparam int CLK_HALF   = 10;         // 20 ns period
  localparam int DRAIN_WAIT = 12;         // lets the back end drain after the last result
  localparam int CYCLE_CAP  = 3_000_000;  // watchdog, far above the slowest legal run
  localparam int LONG_LEN   = 300;        // largest-product pairs in the long dot product

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  in_word_t              in_word   = '0;
  logic                  in_full;
  out_word_t             out_word;
  logic                  out_empty;
  logic                  pop       = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor state: our own copy of the registers and the running dot sum
  cfg_t             scale_cfg;
  logic [ACC_W-1:0] dot_sum;
  out_word_t        pending_activations[$];

  int err_count   = 0;
  int words_sent  = 0;
  int cycle_count = 0;

  // Idle control shared by the sender and the reader
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_left  = 0;   // long reader hold, counted down by the pop process
  int stall_left = 0;   // current short reader stall

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  int8_quantized_linear_relu_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_word  (out_word),
    .out_empty (out_empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Register values after reset; the dot sum starts at zero.
  task automatic reset_model();
    scale_cfg.in_zp       = '0;
    scale_cfg.wgt_zp      = '0;
    scale_cfg.scale_mult  = MULT_RST;
    scale_cfg.scale_shift = SHIFT_RST;
    dot_sum               = '0;
  endtask

  // MAC one word into the wrapping 32-bit sum. On the last word, scale,
  // floor-shift, add the bias, apply ReLU and 47-bit saturation, clear the sum.
  // Returns 1 when the word produces a result.
  function automatic bit neuron_accumulate(input in_word_t w, output out_word_t r);
    int     a_off, w_off;
    longint acc_s, mult, scaled, total, top;
    a_off   = int'($signed(w.act_value)) - int'($signed(scale_cfg.in_zp));
    w_off   = int'($signed(w.wgt_value)) - int'($signed(scale_cfg.wgt_zp));
    dot_sum = dot_sum + ACC_W'(a_off * w_off);
    r = '0;
    if (!w.last_element) return 1'b0;
    acc_s  = longint'($signed(dot_sum));
    mult   = longint'(scale_cfg.scale_mult);
    // >>> on a signed 64-bit value floors, so a shift of 63 on a negative gives -1
    scaled = (acc_s * mult) >>> scale_cfg.scale_shift;
    total  = scaled + longint'($signed(w.bias_value));
    top    = longint'(ACT_MAX);
    if (total > top) begin
      r.activation = ACT_MAX;
      r.saturated  = 1'b1;
    end else if (total > 0) begin
      r.activation = total[OUT_W-1:0];
    end
    dot_sum = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic in_word_t mk(input logic [7:0] a, input logic [7:0] b,
                                  input logic [31:0] bias, input logic last);
    in_word_t w;
    w.act_value    = a;
    w.wgt_value    = b;
    w.bias_value   = bias;
    w.last_element = last;
    return w;
  endfunction

  // Random byte with a bias toward the two extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h80;
      1:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word(input logic last);
    logic [31:0] bias;
    bias = $urandom;
    // a quarter of the biases are small, so the scaled sum is not swamped
    if ($urandom_range(0, 3) == 0) bias = {{16{bias[15]}}, bias[15:0]};
    return mk(pick_byte(), pick_byte(), bias, last);
  endfunction

  // Mostly short dot products, a few long ones.
  function automatic int pick_len();
    case ($urandom_range(0, 19))
      0:             return $urandom_range(41, 200);
      1, 2, 3, 4, 5: return $urandom_range(9, 40);
      default:       return $urandom_range(1, 8);
    endcase
  endfunction

  // Offer one word and wait until the core takes it. in_push is left high so
  // back-to-back words stream at full rate; anything that lets time pass with
  // no word to offer must drop it first.
  task automatic send_word(input in_word_t w);
    out_word_t r;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    if (neuron_accumulate(w, r)) pending_activations.push_back(r);
    words_sent++;
  endtask

  task automatic send_dot_product(input int len);
    for (int i = 0; i < len; i++) send_word(rand_word(i == len - 1));
  endtask

  // Stop offering, wait for every expected result, then let the pipe empty.
  task automatic settle();
    in_push <= 1'b0;
    while (pending_activations.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // One register write. cfg_valid stays high; the caller drops it after a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IN_ZP:  scale_cfg.in_zp       = data[ACT_W-1:0];
      REG_WGT_ZP: scale_cfg.wgt_zp      = data[WGT_W-1:0];
      REG_MULT:   scale_cfg.scale_mult  = data[MULT_W-1:0];
      REG_SHIFT:  scale_cfg.scale_shift = data[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // Program all four registers once the core is idle. Upper data bits carry
  // junk so the core must ignore them.
  task automatic apply_config(input logic [ACT_W-1:0] izp, input logic [WGT_W-1:0] wzp,
                              input logic [MULT_W-1:0] mult,
                              input logic [SHIFT_W-1:0] shift);
    settle();
    write_reg(REG_IN_ZP,  {24'($urandom), izp});
    write_reg(REG_WGT_ZP, {24'($urandom), wzp});
    write_reg(REG_MULT,   {1'($urandom), mult});
    write_reg(REG_SHIFT,  {26'($urandom), shift});
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_config();
    logic [MULT_W-1:0]  m;
    logic [SHIFT_W-1:0] s;
    case ($urandom_range(0, 3))
      0:       m = MULT_W'($urandom);
      1:       m = MULT_W'($urandom_range(0, 1 << 17));
      2:       m = '1;
      default: m = MULT_W'($urandom_range(1 << 12, 1 << 24));
    endcase
    // mostly mid shifts so results are neither all zero nor all saturated
    s = SHIFT_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(12, 40));
    apply_config(pick_byte(), pick_byte(), m, s);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes and every special case, under reset and extreme settings.
  task automatic test_directed();
    // reset settings: scale is 2^-16
    send_word(mk(8'h7F, 8'h7F, 32'h0000_0000, 1'b1));
    send_word(mk(8'h80, 8'h80, 32'h7FFF_FFFF, 1'b1));
    send_word(mk(8'h80, 8'h7F, 32'h0000_0000, 1'b0));
    send_word(mk(8'h80, 8'h7F, 32'hFFFF_FFFF, 1'b0));
    send_word(mk(8'h7F, 8'h80, 32'h8000_0000, 1'b1));   // negative sum, ReLU to 0
    // zero points at opposite extremes, largest multiplier, no shift
    apply_config(8'h80, 8'h7F, 31'h7FFF_FFFF, 6'd0);
    send_word(mk(8'h7F, 8'h80, 32'h0000_0000, 1'b1));
    send_word(mk(8'h80, 8'h7F, 32'h7FFF_FFFF, 1'b1));   // zero offset, bias only
    // both offsets +255: far above 2^47, saturates
    apply_config(8'h80, 8'h80, 31'h7FFF_FFFF, 6'd0);
    send_word(mk(8'h7F, 8'h7F, 32'h1234_5678, 1'b0));
    send_word(mk(8'h7F, 8'h7F, 32'h8000_0000, 1'b1));
    // shift of 63 on a negative product floors to -1
    apply_config(8'h7F, 8'h80, 31'd1, 6'd63);
    send_word(mk(8'h80, 8'h7F, 32'd1, 1'b1));
    send_word(mk(8'h80, 8'h7F, 32'd2, 1'b1));
    // zero multiplier
    apply_config(8'h00, 8'h00, 31'd0, 6'd63);
    send_word(mk(8'h7F, 8'h7F, 32'd5, 1'b1));
    // 65536 * (2^31-1) = 2^47 - 2^16: bias 2^16-1 hits the max exactly,
    // bias 2^16 is one past it
    apply_config(8'h00, 8'h00, 31'h7FFF_FFFF, 6'd0);
    for (int rep = 0; rep < 2; rep++) begin
      for (int i = 0; i < 3; i++) send_word(mk(8'h80, 8'h80, 32'h0, 1'b0));
      send_word(mk(8'h80, 8'h80, (rep == 0) ? 32'h0000_FFFF : 32'h0001_0000, 1'b1));
    end
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_ignored_indices();
    settle();
    for (int idx = REG_SHIFT + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), $urandom);
    cfg_valid <= 1'b0;
    send_dot_product(3);
  endtask

  // A long dot product of the largest products at full rate.
  task automatic test_long_accumulation();
    apply_config(8'h80, 8'h80, 31'd1, 6'd0);
    tx_idle_on = 1'b0;
    // 65025 per pair
    for (int i = 0; i < LONG_LEN - 1; i++) send_word(mk(8'h7F, 8'h7F, $urandom, 1'b0));
    send_word(mk(8'h7F, 8'h7F, 32'h7FFF_FFFF, 1'b1));
    tx_idle_on = 1'b1;
  endtask

  // Bulk random traffic over several settings, idling varied per phase.
  task automatic test_random_phases();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      rand_config();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      target = words_sent + 160;
      while (words_sent < target) send_dot_product(pick_len());
    end
  endtask

  // Reader stalls long while the sender keeps offering last words, so both
  // queues fill and in_full holds the input. Then the sender waits for all
  // results before going on.
  task automatic test_backpressure();
    settle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_left  = 300;
    repeat (40) send_word(rand_word(1'b1));
    settle();
    tx_idle_on = 1'b1;
    repeat (10) send_dot_product($urandom_range(1, 3));
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    int target;
    rand_config();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    target = words_sent + 170;
    while (words_sent < target) send_dot_product($urandom_range(1, 6));
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Reader: random short stalls, plus the long hold requested by a test
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Result checker: every popped word against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && pop && !out_empty) begin
      if (pending_activations.size() == 0) begin
        $display("%0t: unexpected result, expected none, got activation %0d saturated %0b",
                 $time, out_word.activation, out_word.saturated);
        err_count++;
      end else begin
        want = pending_activations.pop_front();
        if (out_word.activation !== want.activation) begin
          $display("%0t: activation mismatch, expected %0d, got %0d",
                   $time, want.activation, out_word.activation);
          err_count++;
        end
        if (out_word.saturated !== want.saturated) begin
          $display("%0t: saturated mismatch, expected %0b, got %0b",
                   $time, want.saturated, out_word.saturated);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_activations.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_ignored_indices();
    test_long_accumulation();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/qlr_pkg.sv
rtl/qlr_midq.sv
rtl/qlr_front.sv
rtl/qlr_back.sv
rtl/int8_quantized_linear_relu_core.sv
sim/tb.sv
